[rtl/fixed_block_pool_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the block pool allocator
// Concurrent checks clocked by clk; empty bodies when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// check outside reset
`define FBPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that also holds while reset is applied
`define FBPA_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBPA_ASSERT(lbl, prop, msg)
`define FBPA_ASSERT_NR(lbl, prop, msg)
`endif

`endif

[rtl/fbpa_pkg.sv]
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants, codes and types of the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
	localparam int ADDR_W     = 32;
	localparam int SIZE_W     = 16;
	localparam int CNT_W      = 11;
	localparam int PROD_W     = LINK_W + SIZE_W;
	localparam int DCNT_W     = $clog2(LINK_W);
	localparam int CFG_AW     = 4;
	localparam int CFG_DW     = 32;

	localparam logic [SIZE_W-1:0] SIZE_RST  = SIZE_W'(64);
	localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(1024);

	typedef enum logic [1:0] {
		REG_POOL_BASE   = 2'd0,
		REG_BLOCK_SIZE  = 2'd1,
		REG_BLOCK_COUNT = 2'd2,
		REG_UNUSED      = 2'd3
	} fbpa_reg_t;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_INIT    = 2'd2,
		OP_NOP     = 2'd3
	} fbpa_op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_CONFIG    = 2'd1,
		STS_EXHAUSTED = 2'd2,
		STS_BAD_INDEX = 2'd3
	} fbpa_status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_ALLOC_RD,
		ST_ALLOC_UPD,
		ST_REL_LIM,
		ST_REL_CHK,
		ST_REL_DIV,
		ST_REL_UPD,
		ST_INIT,
		ST_REPLY
	} fbpa_state_t;

	typedef struct packed {
		logic [1:0]        opcode;
		logic [ADDR_W-1:0] release_address;
	} fbpa_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_address;
		logic [CNT_W-1:0]  used_blocks;
		logic [CNT_W-1:0]  free_blocks;
	} fbpa_rsp_t;

	typedef struct packed {
		logic [ADDR_W-1:0] pool_base;
		logic [SIZE_W-1:0] block_size;
		logic [CNT_W-1:0]  block_count;
	} fbpa_cfg_t;

	// controller to datapath
	typedef struct packed {
		logic         sweep;
		logic         capture;
		logic         mul_cnt;
		logic         alloc_commit;
		logic         div_load;
		logic         div_step;
		logic         rel_commit;
		logic         reply;
		logic         addr_ok;
		fbpa_status_t status;
	} fbpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		fbpa_op_t opcode;
		logic     cfg_ok;
		logic     exhausted;
		logic     over_limit;
		logic     div_last;
		logic     sweep_last;
	} fbpa_sts_t;

endpackage

[rtl/fixed_block_pool_allocator_core.sv]
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool allocator: a linked free list in a next-link memory,
// with allocate, release and initialize commands and an APB register port.
// ----------------------------------------------------------------------------
//
//  channel   handshake                          payload
//  --------  ---------------------------------  ------------------------------
//  command   item taken when start && !busy     req    (opcode, release addr)
//  result    one-cycle strobe on done           rsp    (status, address, counts)
//  config    write on psel&penable&pwrite       paddr/pwdata, prdata, pready=1
//
//  Release runs the 11-step restoring divider and initialize makes one link
//  write per cycle; a configuration error, opcode 3 or a release past the
//  pool goes to the reply early with its status. busy drops as done rises, so
//  the next item is taken in the done cycle. After reset a clear pass rebuilds
//  the link memory with busy high. Registers are written any time; results
//  never stall.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// register port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fbpa_pkg::CFG_AW-1:0] paddr,
	input  logic [fbpa_pkg::CFG_DW-1:0] pwdata,
	output logic [fbpa_pkg::CFG_DW-1:0] prdata,
	output logic                        pready,
	// command side
	input  logic                        start,
	output logic                        busy,
	input  fbpa_pkg::fbpa_req_t         req,
	// result side
	output logic                        done,
	output fbpa_pkg::fbpa_rsp_t         rsp
);
	import fbpa_pkg::*;

	fbpa_cfg_t cfg;
	fbpa_cmd_t cmd;
	fbpa_sts_t sts;

	// register file: pool base, block size, block count
	fbpa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: owns busy and drives every datapath step
	fbpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath: link memory, head, usage count, multiplier, divider, result
	fbpa_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

endmodule

[rtl/fbpa_cfg.sv]
// ----------------------------------------------------------------------------
// fbpa_cfg
// APB register file: pool base, block size and block count.
// ----------------------------------------------------------------------------
module fbpa_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [fbpa_pkg::CFG_AW-1:0] paddr,
	input  logic [fbpa_pkg::CFG_DW-1:0] pwdata,
	output logic [fbpa_pkg::CFG_DW-1:0] prdata,
	output logic                      pready,
	output fbpa_pkg::fbpa_cfg_t       cfg
);
	import fbpa_pkg::*;

	logic [ADDR_W-1:0] pool_base_q;
	logic [SIZE_W-1:0] block_size_q;
	logic [CNT_W-1:0]  block_count_q;
	logic              wr_en;
	fbpa_reg_t         reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = fbpa_reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q   <= '0;
			block_size_q  <= SIZE_RST;
			block_count_q <= COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_POOL_BASE:   pool_base_q   <= pwdata[ADDR_W-1:0];
				REG_BLOCK_SIZE:  block_size_q  <= pwdata[SIZE_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[CNT_W-1:0];
				REG_UNUSED:      ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_POOL_BASE:   prdata = CFG_DW'(pool_base_q);
			REG_BLOCK_SIZE:  prdata = CFG_DW'(block_size_q);
			REG_BLOCK_COUNT: prdata = CFG_DW'(block_count_q);
			REG_UNUSED:      prdata = '0;
		endcase
	end

	assign cfg.pool_base   = pool_base_q;
	assign cfg.block_size  = block_size_q;
	assign cfg.block_count = block_count_q;

endmodule

[rtl/fbpa_ctrl.sv]
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Sequencer: decodes an item, steps the datapath and issues the reply.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  fbpa_pkg::fbpa_sts_t sts,
	output fbpa_pkg::fbpa_cmd_t cmd
);
	import fbpa_pkg::*;

	fbpa_state_t  state_q, state_d;
	fbpa_status_t status_q, status_d;
	logic         addr_ok_q, addr_ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			status_q  <= STS_OK;
			addr_ok_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			status_q  <= status_d;
			addr_ok_q <= addr_ok_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		status_d    = status_q;
		addr_ok_d   = addr_ok_q;
		cmd         = '0;
		cmd.status  = status_q;
		cmd.addr_ok = addr_ok_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					status_d    = STS_OK;
					addr_ok_d   = 1'b0;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.opcode)
					OP_ALLOC: begin
						if (!sts.cfg_ok) begin
							status_d = STS_CONFIG;
							state_d  = ST_REPLY;
						end else if (sts.exhausted) begin
							status_d = STS_EXHAUSTED;
							state_d  = ST_REPLY;
						end else begin
							state_d = ST_ALLOC_RD;
						end
					end
					OP_RELEASE: begin
						if (!sts.cfg_ok) begin
							status_d = STS_CONFIG;
							state_d  = ST_REPLY;
						end else begin
							state_d = ST_REL_LIM;
						end
					end
					OP_INIT: begin
						if (!sts.cfg_ok) begin
							status_d = STS_CONFIG;
							state_d  = ST_REPLY;
						end else begin
							state_d = ST_INIT;
						end
					end
					OP_NOP: begin
						state_d = ST_REPLY;
					end
				endcase
			end
			ST_ALLOC_RD: begin
				state_d = ST_ALLOC_UPD;
			end
			ST_ALLOC_UPD: begin
				cmd.alloc_commit = 1'b1;
				addr_ok_d        = 1'b1;
				state_d          = ST_REPLY;
			end
			ST_REL_LIM: begin
				cmd.mul_cnt = 1'b1;
				state_d     = ST_REL_CHK;
			end
			ST_REL_CHK: begin
				if (sts.over_limit) begin
					status_d = STS_BAD_INDEX;
					state_d  = ST_REPLY;
				end else begin
					cmd.div_load = 1'b1;
					state_d      = ST_REL_DIV;
				end
			end
			ST_REL_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_REL_UPD;
				end
			end
			ST_REL_UPD: begin
				cmd.rel_commit = 1'b1;
				state_d        = ST_REPLY;
			end
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_REPLY;
				end
			end
			ST_REPLY: begin
				cmd.reply = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`FBPA_ASSERT_NR(a_busy_in_reset, !arst_n |=> busy, "idle while reset is applied")
	`FBPA_ASSERT(a_start_decodes, (state_q == ST_IDLE && start) |=> (state_q == ST_DECODE),
		"accepted item did not reach decode")
	`FBPA_ASSERT(a_busy_falls, $fell(busy) |-> ($past(state_q) == ST_REPLY ||
		$past(state_q) == ST_CLEAR), "busy dropped without reply or end of clear pass")
	`FBPA_ASSERT(a_div_runs, (state_q == ST_REL_DIV && !sts.div_last) |=>
		(state_q == ST_REL_DIV), "divider left before its last step")

endmodule

[rtl/fbpa_dp.sv]
// ----------------------------------------------------------------------------
// fbpa_dp
// Datapath: next-link memory, list head, usage count, shared multiplier,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fbpa_pkg::fbpa_cfg_t cfg,
	input  fbpa_pkg::fbpa_req_t req,
	input  fbpa_pkg::fbpa_cmd_t cmd,
	output fbpa_pkg::fbpa_sts_t sts,
	output logic                done,
	output fbpa_pkg::fbpa_rsp_t rsp
);
	import fbpa_pkg::*;

	logic [LINK_W-1:0] link_mem [MAX_BLOCKS];
	logic [LINK_W-1:0] rd_q;

	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] in_use_q;
	logic [IDX_W-1:0]  sweep_cnt_q;
	logic [DCNT_W-1:0] div_cnt_q;
	logic              done_q;

	fbpa_req_t         req_q;
	logic [ADDR_W-1:0] offset_q;
	logic [PROD_W-1:0] prod_q;
	logic [ADDR_W-1:0] addr_q;
	logic [PROD_W-1:0] rem_q;
	logic [PROD_W-1:0] dvs_q;
	logic [LINK_W-1:0] quo_q;
	fbpa_rsp_t         rsp_q;

	logic [LINK_W-1:0] cnt_eff;
	logic [LINK_W-1:0] mul_a;
	logic [LINK_W-1:0] free_n;
	logic              rem_ge;
	logic              sweep_last;

	// clamp the configured count to the memory depth
	assign cnt_eff = (32'(cfg.block_count) > 32'(MAX_BLOCKS)) ? LINK_W'(MAX_BLOCKS)
		: LINK_W'(cfg.block_count);
	assign free_n     = (cnt_eff > in_use_q) ? (cnt_eff - in_use_q) : '0;
	assign sweep_last = (sweep_cnt_q == IDX_W'(MAX_BLOCKS - 1));
	assign rem_ge     = (rem_q >= dvs_q);
	assign mul_a      = cmd.mul_cnt ? cnt_eff : head_q;

	// link memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.sweep) begin
			link_mem[sweep_cnt_q] <= LINK_W'(sweep_cnt_q) + LINK_W'(1);
		end else if (cmd.rel_commit) begin
			link_mem[quo_q[IDX_W-1:0]] <= head_q;
		end
		rd_q <= link_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			in_use_q    <= '0;
			sweep_cnt_q <= '0;
			div_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.reply;
			if (cmd.sweep) begin
				sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + IDX_W'(1);
				head_q      <= '0;
				in_use_q    <= '0;
			end else if (cmd.alloc_commit) begin
				head_q   <= rd_q;
				in_use_q <= in_use_q + LINK_W'(1);
			end else if (cmd.rel_commit) begin
				head_q <= quo_q;
				if (in_use_q != '0) begin
					in_use_q <= in_use_q - LINK_W'(1);
				end
			end
			if (cmd.div_load) begin
				div_cnt_q <= DCNT_W'(LINK_W - 1);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - DCNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		offset_q <= req_q.release_address - cfg.pool_base;
		prod_q   <= PROD_W'(mul_a) * PROD_W'(cfg.block_size);
		if (cmd.alloc_commit) begin
			addr_q <= cfg.pool_base + ADDR_W'(prod_q);
		end
		if (cmd.div_load) begin
			rem_q <= offset_q[PROD_W-1:0];
			dvs_q <= PROD_W'(cfg.block_size) << (LINK_W - 1);
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (rem_ge) begin
				rem_q <= rem_q - dvs_q;
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[LINK_W-2:0], rem_ge};
		end
		if (cmd.reply) begin
			rsp_q.status        <= cmd.status;
			rsp_q.block_address <= cmd.addr_ok ? addr_q : '0;
			rsp_q.used_blocks   <= CNT_W'(in_use_q);
			rsp_q.free_blocks   <= CNT_W'(free_n);
		end
	end

	assign sts.opcode     = fbpa_op_t'(req_q.opcode);
	assign sts.cfg_ok     = (cfg.block_size != '0) && (cnt_eff != '0);
	assign sts.exhausted  = (in_use_q >= cnt_eff) || (head_q >= cnt_eff);
	assign sts.over_limit = (offset_q >= ADDR_W'(prod_q));
	assign sts.div_last   = (div_cnt_q == '0);
	assign sts.sweep_last = sweep_last;

	assign done = done_q;
	assign rsp  = rsp_q;

	`FBPA_ASSERT(a_done_pulse, done_q |=> !done_q, "result strobe held for two cycles")
	`FBPA_ASSERT(a_rel_index, cmd.rel_commit |-> (quo_q < cnt_eff),
		"released index not below the block count")
	`FBPA_ASSERT(a_alloc_head, cmd.alloc_commit |-> (head_q < cnt_eff && in_use_q < cnt_eff),
		"allocation from an exhausted pool")
	`FBPA_ASSERT(a_addr_only_ok, (done_q && rsp_q.status != STS_OK) |->
		(rsp_q.block_address == '0), "address returned with an error status")

endmodule
